[rtl/awd_pkg.sv]
`timescale 1ns / 1ps
package awd_pkg;

    localparam int CURVE_TABLE_BITS = 10;
    localparam int TAB_N            = 1 << CURVE_TABLE_BITS;
    localparam int IDX_W            = CURVE_TABLE_BITS + 1;
    // sine position fraction; the tanh fraction is shifted up to this width
    localparam int FRAC_W           = 30 - CURVE_TABLE_BITS;
    localparam int TANH_FRAC_W      = 26 - CURVE_TABLE_BITS;

    localparam int SMP_W     = 24;
    localparam int D_W       = 31;
    localparam int S_W       = 33;
    localparam int NUM_W     = 56;
    localparam int REM_W     = 56;
    localparam int Q_W       = 33;
    localparam int DIV_STEPS = Q_W;
    localparam int LOW_W     = 9;
    localparam int REST_W    = LOW_W + 24;
    localparam int O_W       = 41;

    localparam logic [28:0] PHASE_K = 29'd341782638;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_TANH = 2'd1,
        MODE_SOFT = 2'd2,
        MODE_SINE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_SHAPE_MODE  = 2'd0,
        REG_INPUT_GAIN  = 2'd1,
        REG_OUTPUT_GAIN = 2'd2,
        REG_CLIP_COEF   = 2'd3
    } t_reg;

    typedef logic [SMP_W-1:0] t_tab [0:TAB_N];

    typedef struct packed {
        logic              valid;
        logic              neg;
        t_mode             mode;
        logic [S_W-1:0]    s;
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  den;
        logic [REST_W-1:0] rest;
        logic [Q_W-1:0]    q;
    } t_div;

    // restoring long division, used only while building the tables
    function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
        logic [64:0]     rem;
        longint unsigned q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tab tanh_table();
        t_tab              tab;
        longint unsigned   y;
        longint unsigned   term;
        longint unsigned   r;
        longint unsigned   p;
        longint unsigned   num;
        longint unsigned   den;
        longint            acc;
        y    = 64'd1 << (34 - CURVE_TABLE_BITS);
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            term = cdiv((term * y) >> 30, 64'(n));
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        r = longint'(acc);
        p = 64'd1 << 30;
        for (int i = 0; i <= TAB_N; i++) begin
            num    = ((64'd1 << 30) - p) << 24;
            den    = ((64'd1 << 30) + p) * 64'd2;
            tab[i] = SMP_W'(cdiv(num + ((64'd1 << 30) + p), den));
            p      = (p * r + (64'd1 << 29)) >> 30;
            if (p > (64'd1 << 30)) p = 64'd1 << 30;
        end
        return tab;
    endfunction

    function automatic t_tab sine_table();
        t_tab              tab;
        longint unsigned   t;
        longint unsigned   t2;
        longint unsigned   term;
        longint            s;
        for (int i = 0; i <= TAB_N; i++) begin
            t    = (64'd1686629713 * longint'(i) + longint'(TAB_N >> 1)) >> CURVE_TABLE_BITS;
            t2   = (t * t) >> 30;
            s    = longint'(t);
            term = t;
            for (int n = 1; n <= 9; n++) begin
                term = cdiv((term * t2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if (n % 2 == 1) s = s - longint'(term);
                else s = s + longint'(term);
            end
            if (s < 0) s = 0;
            tab[i] = SMP_W'((longint'(s) + 64'd64) >> 7);
        end
        return tab;
    endfunction

endpackage

[rtl/awd_curve_rom.sv]
`timescale 1ns / 1ps
module awd_curve_rom (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_sel,
    input  logic [awd_pkg::IDX_W-1:0]   i_addr_a,
    input  logic [awd_pkg::IDX_W-1:0]   i_addr_b,
    output logic [awd_pkg::SMP_W-1:0]   o_a,
    output logic [awd_pkg::SMP_W-1:0]   o_b
);

    localparam awd_pkg::t_tab TANH_ROM = awd_pkg::tanh_table();
    localparam awd_pkg::t_tab SINE_ROM = awd_pkg::sine_table();

    logic [awd_pkg::SMP_W-1:0] r_a;
    logic [awd_pkg::SMP_W-1:0] r_b;

    // i_sel high picks the quarter-wave sine table
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_sel ? SINE_ROM[i_addr_a] : TANH_ROM[i_addr_a];
            r_b <= i_sel ? SINE_ROM[i_addr_b] : TANH_ROM[i_addr_b];
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

[rtl/awd_div_cell.sv]
`timescale 1ns / 1ps
module awd_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  awd_pkg::t_div i_stage,
    output awd_pkg::t_div o_stage
);

    awd_pkg::t_div              r_stage;
    awd_pkg::t_div              n_stage;
    logic [awd_pkg::REM_W:0]    w_try;
    logic [awd_pkg::REM_W:0]    w_diff;
    logic                       w_take;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_try   = {i_stage.rem, i_stage.rest[awd_pkg::REST_W-1]};
        w_diff  = w_try - {1'b0, i_stage.den};
        w_take  = (w_try >= {1'b0, i_stage.den});
        n_stage = i_stage;
        n_stage.rem  = w_take ? w_diff[awd_pkg::REM_W-1:0] : w_try[awd_pkg::REM_W-1:0];
        n_stage.rest = {i_stage.rest[awd_pkg::REST_W-2:0], 1'b0};
        n_stage.q    = {i_stage.q[awd_pkg::Q_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[rtl/audio_waveshaper_distortion.sv]
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_sample_in
// output    out        o_valid / i_ready    o_sample_out, o_saturated
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the skid entry is empty; the path runs through
// the 33-cell soft clip divider row plus gain, table and output stages
// reset (synchronous, active low) clears the valid bits and loads register defaults
// a two-entry output register and skid stage keep the pipeline moving while a
// result waits; o_ready drops only once the skid entry is full
module audio_waveshaper_distortion (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [23:0]          i_sample_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [23:0]          o_sample_out,
    output logic                        o_saturated,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [23:0]                 i_cfg_data
);

    localparam int IW = awd_pkg::IDX_W;
    localparam int FW = awd_pkg::FRAC_W;
    localparam int TW = awd_pkg::TANH_FRAC_W;
    localparam int PW = 26 + awd_pkg::FRAC_W;

    // configuration
    awd_pkg::t_mode r_shape_mode;
    logic [23:0]    r_input_gain;
    logic [23:0]    r_output_gain;
    logic [23:0]    r_clip_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode  <= awd_pkg::MODE_PASS;
            r_input_gain  <= 24'd65536;
            r_output_gain <= 24'd65536;
            r_clip_coef   <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (awd_pkg::t_reg'(i_cfg_index))
                awd_pkg::REG_SHAPE_MODE:  r_shape_mode  <= awd_pkg::t_mode'(i_cfg_data[1:0]);
                awd_pkg::REG_INPUT_GAIN:  r_input_gain  <= i_cfg_data;
                awd_pkg::REG_OUTPUT_GAIN: r_output_gain <= i_cfg_data;
                awd_pkg::REG_CLIP_COEF:   r_clip_coef   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_v;
    logic r_skid_v;
    logic w_en;

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    // stage a: magnitude times drive gain
    logic [23:0]              w_mag;
    logic [47:0]              w_sum_a;
    logic                     r_v_a;
    logic                     r_neg_a;
    logic [awd_pkg::D_W-1:0]  r_d_a;

    assign w_mag   = i_sample_in[23] ? 24'(~$unsigned(i_sample_in) + 24'd1)
                                     : $unsigned(i_sample_in);
    assign w_sum_a = (48'(w_mag) * 48'(r_input_gain)) + 48'h8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_a <= 1'b0;
        else if (w_en) r_v_a <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_a <= i_sample_in[23];
            r_d_a   <= w_sum_a[46:16];
        end
    end

    // stage b: table position, sine phase and quadrant
    logic [59:0]              w_phase_full;
    logic [31:0]              w_phase;
    logic [30:0]              w_pos;
    logic                     w_big;
    logic [IW-1:0]            w_idx;
    logic [FW-1:0]            w_frac;
    logic                     w_flip;
    logic                     r_v_b;
    logic                     r_neg_b;
    logic [IW-1:0]            r_idx_b;
    logic [FW-1:0]            r_frac_b;
    logic [awd_pkg::D_W-1:0]  r_d_b;

    always_comb begin
        w_phase_full = (60'(r_d_a) * 60'(awd_pkg::PHASE_K)) + 60'h400000;
        w_phase      = w_phase_full[54:23];
        // odd quadrants run the quarter wave backwards
        w_pos        = w_phase[30] ? (31'h40000000 - {1'b0, w_phase[29:0]})
                                   : {1'b0, w_phase[29:0]};
        w_big        = (r_d_a[awd_pkg::D_W-1:26] != '0);
        w_flip       = 1'b0;
        if (r_shape_mode == awd_pkg::MODE_SINE) begin
            w_idx  = w_pos[30:FW];
            w_frac = w_pos[FW-1:0];
            w_flip = w_phase[31];
        end else if (w_big) begin
            // tanh saturates to its last entry past the table span
            w_idx  = IW'(awd_pkg::TAB_N);
            w_frac = '0;
        end else begin
            w_idx  = {1'b0, r_d_a[25:TW]};
            w_frac = {r_d_a[TW-1:0], {(FW - TW){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_b <= 1'b0;
        else if (w_en) r_v_b <= r_v_a;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_b  <= r_neg_a ^ w_flip;
            r_idx_b  <= w_idx;
            r_frac_b <= w_frac;
            r_d_b    <= r_d_a;
        end
    end

    // stage c: table read, soft clip numerator and denominator
    logic [IW-1:0]              w_addr_b;
    logic [awd_pkg::SMP_W-1:0]  w_tab_a;
    logic [awd_pkg::SMP_W-1:0]  w_tab_b;
    logic                       r_v_c;
    logic                       r_neg_c;
    logic [FW-1:0]              r_frac_c;
    logic [awd_pkg::D_W-1:0]    r_d_c;
    logic [awd_pkg::NUM_W-1:0]  r_num_c;
    logic [awd_pkg::REM_W-1:0]  r_den_c;

    assign w_addr_b = (r_idx_b == IW'(awd_pkg::TAB_N)) ? r_idx_b : r_idx_b + IW'(1);

    awd_curve_rom u_rom (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sel    (r_shape_mode == awd_pkg::MODE_SINE),
        .i_addr_a (r_idx_b),
        .i_addr_b (w_addr_b),
        .o_a      (w_tab_a),
        .o_b      (w_tab_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_c <= 1'b0;
        else if (w_en) r_v_c <= r_v_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_c  <= r_neg_b;
            r_frac_c <= r_frac_b;
            r_d_c    <= r_d_b;
            r_num_c  <= awd_pkg::NUM_W'((56'(r_clip_coef) + 56'h10000) * 56'(r_d_b));
            r_den_c  <= awd_pkg::REM_W'(56'(r_clip_coef) * 56'(r_d_b)) + 56'h80_0000_0000;
        end
    end

    // stage d: interpolation, then load the divider row
    logic signed [24:0]         w_diff;
    logic signed [PW-1:0]       w_prod;
    logic signed [PW-1:0]       w_rnd;
    logic signed [PW-1:0]       w_t;
    logic [awd_pkg::SMP_W-1:0]  w_s_tab;
    awd_pkg::t_div              r_div_in;
    awd_pkg::t_div              w_chain [0:awd_pkg::DIV_STEPS];

    always_comb begin
        w_diff  = $signed({1'b0, w_tab_b}) - $signed({1'b0, w_tab_a});
        w_prod  = PW'(w_diff) * $signed(PW'({1'b0, r_frac_c}));
        w_rnd   = w_prod + $signed({{(PW - FW){1'b0}}, 1'b1, {(FW - 1){1'b0}}});
        w_t     = w_rnd >>> FW;
        w_s_tab = w_tab_a + w_t[awd_pkg::SMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_in <= '0;
        end else if (w_en) begin
            r_div_in.valid <= r_v_c;
            r_div_in.neg   <= r_neg_c;
            r_div_in.mode  <= r_shape_mode;
            r_div_in.s     <= (r_shape_mode == awd_pkg::MODE_PASS) ? awd_pkg::S_W'(r_d_c)
                                                                   : awd_pkg::S_W'(w_s_tab);
            r_div_in.rem   <= awd_pkg::REM_W'(r_num_c[awd_pkg::NUM_W-1:awd_pkg::LOW_W]);
            r_div_in.den   <= r_den_c;
            r_div_in.rest  <= {r_num_c[awd_pkg::LOW_W-1:0],
                               {(awd_pkg::REST_W - awd_pkg::LOW_W){1'b0}}};
            r_div_in.q     <= '0;
        end
    end

    assign w_chain[0] = r_div_in;

    for (genvar g = 0; g < awd_pkg::DIV_STEPS; g++) begin : g_div
        awd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // stage e: output gain
    awd_pkg::t_div           w_last;
    logic [awd_pkg::Q_W:0]   w_q1;
    logic [awd_pkg::S_W-1:0] w_s_fin;
    logic [56:0]             w_sum_e;
    logic                    r_v_e;
    logic                    r_neg_e;
    logic [awd_pkg::O_W-1:0] r_o_e;

    always_comb begin
        w_last  = w_chain[awd_pkg::DIV_STEPS];
        w_q1    = {1'b0, w_last.q} + (awd_pkg::Q_W + 1)'(1);
        w_s_fin = (w_last.mode == awd_pkg::MODE_SOFT) ? w_q1[awd_pkg::Q_W:1] : w_last.s;
        w_sum_e = (57'(w_s_fin) * 57'(r_output_gain)) + 57'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_e <= 1'b0;
        else if (w_en) r_v_e <= w_last.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg_e <= w_last.neg;
            r_o_e   <= w_sum_e[56:16];
        end
    end

    // saturation and sign
    logic [23:0] w_res;
    logic        w_sat;

    always_comb begin
        w_res = '0;
        w_sat = 1'b0;
        if (r_o_e == '0) begin
            w_res = '0;
        end else if (r_neg_e) begin
            if (r_o_e > awd_pkg::O_W'(24'h800000)) begin
                w_res = 24'h800000;
                w_sat = 1'b1;
            end else begin
                w_res = 24'(~r_o_e[23:0] + 24'd1);
            end
        end else begin
            if (r_o_e > awd_pkg::O_W'(24'h7fffff)) begin
                w_res = 24'h7fffff;
                w_sat = 1'b1;
            end else begin
                w_res = r_o_e[23:0];
            end
        end
    end

    // output register with skid entry
    logic [23:0] r_out_res;
    logic        r_out_sat;
    logic [23:0] r_skid_res;
    logic        r_skid_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_v <= r_v_e;
        end else if (r_v_e) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out_res <= r_skid_res;
                r_out_sat <= r_skid_sat;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_res <= w_res;
            r_out_sat <= w_sat;
        end else if (r_v_e) begin
            r_skid_res <= w_res;
            r_skid_sat <= w_sat;
        end
    end

    assign o_valid      = r_out_v;
    assign o_sample_out = $signed(r_out_res);
    assign o_saturated  = r_out_sat;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output item");

    a_skid_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !o_ready)
        else $error("input ready while skid entry is full");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            ($unsigned(o_sample_out) == 24'h7fffff || $unsigned(o_sample_out) == 24'h800000))
        else $error("saturated item not at a range limit");
`endif

endmodule
